/* hdl/sepq_pkg.sv */
// ----------------------------------------------------------------------------
// sepq_pkg
// Types and constants shared by the sorted event priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sepq_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned TAG_W  = 3;
    localparam int unsigned OCC_W  = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_INS_CMP,
        ST_INS_HEAD,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic              item_valid;
        logic [TIME_W-1:0] out_time;
        logic [KIND_W-1:0] out_kind;
        logic [TAG_W-1:0]  out_tag;
        t_status           status;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

endpackage

`default_nettype wire

/* hdl/sepq_core.sv */
// ----------------------------------------------------------------------------
// sepq_core
// Sorted event store in a circular memory, with the insert and pop sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sepq_core #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_action,
    input  logic [sepq_pkg::TIME_W-1:0]   i_time_key,
    input  logic [sepq_pkg::KIND_W-1:0]   i_event_kind,
    input  logic [sepq_pkg::TAG_W-1:0]    i_event_tag,
    output logic                          o_ready,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output sepq_pkg::t_result             o_res
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LW = sepq_pkg::KIND_W + sepq_pkg::TAG_W;
    localparam int unsigned EW = KEY_BITS + LW;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
        return r;
    endfunction

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rd_data;

    sepq_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_left, n_left;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [LW-1:0]     r_label, n_label;
    sepq_pkg::t_result r_res, n_res;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;

    logic [KEY_BITS-1:0] w_in_key;
    logic [KEY_BITS-1:0] w_rd_key;
    logic                w_shift;

    assign w_in_key = KEY_BITS'(i_time_key);
    assign w_rd_key = r_rd_data[EW-1:LW];
    assign w_shift  = (w_rd_key > r_key);

    always_comb begin
        n_state = r_state;
        case (r_state)
            sepq_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_action == sepq_pkg::ACT_POP) begin
                        n_state = (r_count == '0) ? sepq_pkg::ST_RESP : sepq_pkg::ST_POP;
                    end else if (r_count == CW'(DEPTH) || r_count == '0) begin
                        n_state = sepq_pkg::ST_RESP;
                    end else begin
                        n_state = sepq_pkg::ST_INS_CMP;
                    end
                end
            end
            sepq_pkg::ST_POP: begin
                n_state = sepq_pkg::ST_RESP;
            end
            sepq_pkg::ST_INS_CMP: begin
                if (!w_shift) begin
                    n_state = sepq_pkg::ST_RESP;
                end else if (r_left == CW'(1)) begin
                    n_state = sepq_pkg::ST_INS_HEAD;
                end
            end
            sepq_pkg::ST_INS_HEAD: begin
                n_state = sepq_pkg::ST_RESP;
            end
            sepq_pkg::ST_RESP: begin
                if (i_res_take) begin
                    n_state = sepq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sepq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_left   = r_left;
        n_key    = r_key;
        n_label  = r_label;
        n_res    = r_res;
        w_we     = 1'b0;
        w_waddr  = r_wr_ptr;
        w_wdata  = {r_key, r_label};
        w_re     = 1'b0;
        w_raddr  = r_rd_ptr;
        o_ready  = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            sepq_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_key   = w_in_key;
                    n_label = {i_event_kind, i_event_tag};
                    n_res   = '0;
                    if (i_action == sepq_pkg::ACT_POP) begin
                        if (r_count == '0) begin
                            n_res.status = sepq_pkg::STATUS_EMPTY;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = r_head;
                        end
                    end else if (r_count == CW'(DEPTH)) begin
                        n_res.status    = sepq_pkg::STATUS_FULL;
                        n_res.occupancy = sepq_pkg::OCC_W'(r_count);
                    end else if (r_count == '0) begin
                        w_we    = 1'b1;
                        w_waddr = r_tail;
                        w_wdata = {w_in_key, i_event_kind, i_event_tag};
                        n_tail  = ptr_inc(r_tail);
                        n_count = CW'(1);
                        n_res.occupancy = sepq_pkg::OCC_W'(1);
                    end else begin
                        w_re     = 1'b1;
                        w_raddr  = ptr_dec(r_tail);
                        n_wr_ptr = r_tail;
                        n_rd_ptr = ptr_dec(r_tail);
                        n_left   = r_count;
                    end
                end
            end
            sepq_pkg::ST_POP: begin
                n_res.item_valid = 1'b1;
                n_res.out_time   = sepq_pkg::TIME_W'(w_rd_key);
                n_res.out_kind   = r_rd_data[LW-1:sepq_pkg::TAG_W];
                n_res.out_tag    = r_rd_data[sepq_pkg::TAG_W-1:0];
                n_res.status     = sepq_pkg::STATUS_OK;
                n_res.occupancy  = sepq_pkg::OCC_W'(r_count - 1'b1);
                n_head  = ptr_inc(r_head);
                n_count = r_count - 1'b1;
            end
            sepq_pkg::ST_INS_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_wr_ptr;
                if (w_shift) begin
                    w_wdata  = r_rd_data;
                    n_wr_ptr = r_rd_ptr;
                    n_rd_ptr = ptr_dec(r_rd_ptr);
                    n_left   = r_left - 1'b1;
                    if (r_left != CW'(1)) begin
                        w_re    = 1'b1;
                        w_raddr = ptr_dec(r_rd_ptr);
                    end
                end else begin
                    n_tail  = ptr_inc(r_tail);
                    n_count = r_count + 1'b1;
                    n_res.occupancy = sepq_pkg::OCC_W'(r_count + 1'b1);
                end
            end
            sepq_pkg::ST_INS_HEAD: begin
                w_we    = 1'b1;
                n_tail  = ptr_inc(r_tail);
                n_count = r_count + 1'b1;
                n_res.occupancy = sepq_pkg::OCC_W'(r_count + 1'b1);
            end
            sepq_pkg::ST_RESP: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sepq_pkg::ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_ptr <= n_wr_ptr;
        r_rd_ptr <= n_rd_ptr;
        r_left   <= n_left;
        r_key    <= n_key;
        r_label  <= n_label;
        r_res    <= n_res;
    end

endmodule

`default_nettype wire

/* hdl/sorted_event_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_event_priority_queue
// Event queue kept in ascending time-key order: insert an event, pop the head.
// ----------------------------------------------------------------------------
// Each input item on the s-side stream is one operation: tuser selects insert
// or pop, tdata carries the time key (unsigned Q24.8), kind and tag. Every
// operation returns exactly one item on the m-side stream with the popped
// event, a status code and the occupancy after the operation. Equal keys
// leave in arrival order. An insert into a full queue is dropped with status
// full; a pop on an empty queue returns status empty.
// The events sit in one single-port-write, registered-read memory used as a
// ring; a pop advances the head pointer, an insert walks back from the tail
// one entry a cycle, moving larger keys up by one slot.
// An empty pop, a full insert and an insert into an empty queue go straight
// to the response state; a pop reads the head first, and an insert into a
// filled queue compares and moves entries first. The sequencer takes one
// item at a time; the next item is accepted once the result leaves the
// sequencer, even while the output register waits on a stalled receiver.
// Reset empties the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_priority_queue #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // time_key[31:0], event_kind[33:32], event_tag[36:34]
    input  logic [0:0]  i_s_tuser,  // action[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,  // out_time[31:0], out_kind[33:32], out_tag[36:34],
                                    // occupancy[41:37]
    output logic [2:0]  o_m_tuser   // item_valid[0], status[2:1]
);

    logic              w_start;
    logic              w_res_valid;
    logic              w_res_take;
    sepq_pkg::t_result w_res;
    logic              r_m_valid;
    sepq_pkg::t_result r_m_res;

    assign w_start    = i_s_tvalid && o_s_tready;
    assign w_res_take = w_res_valid && (!r_m_valid || i_m_tready);

    sepq_core #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_action     (i_s_tuser[0]),
        .i_time_key   (i_s_tdata[31:0]),
        .i_event_kind (i_s_tdata[33:32]),
        .i_event_tag  (i_s_tdata[36:34]),
        .o_ready      (o_s_tready),
        .o_res_valid  (w_res_valid),
        .i_res_take   (w_res_take),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_take) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_m_res.occupancy, r_m_res.out_tag, r_m_res.out_kind,
                         r_m_res.out_time};
    assign o_m_tuser  = {r_m_res.status, r_m_res.item_valid};

endmodule

`default_nettype wire

/* dv/tb_sorted_event_priority_queue.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_event_priority_queue
// Self-checking bench for the sorted event priority queue.
// ----------------------------------------------------------------------------
// A short directed sequence opens the run. It covers pops on an empty queue,
// the extreme time keys, kind and tag values, and ties on equal keys. The
// random part then alternates fill and drain bursts, which take the queue to
// full, produce dropped inserts, and empty it again. Key values mix tight
// ranges, which force ties, with full-range values.
// A scoreboard class holds its own sorted copy of the queue. It predicts one
// result for every accepted operation and checks each returned item field by
// field. Idling on both streams follows three phases. One phase contains a
// long receiver hold-off, and in another the sender pauses until the queue's
// results have all returned.
// ----------------------------------------------------------------------------

module tb_sorted_event_priority_queue;

    localparam int unsigned QDEPTH       = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_ITEMS  = 150;

    class event_queue_scoreboard;
        logic [sepq_pkg::TIME_W-1:0] slot_time [QDEPTH];
        logic [sepq_pkg::KIND_W-1:0] slot_kind [QDEPTH];
        logic [sepq_pkg::TAG_W-1:0]  slot_tag  [QDEPTH];
        int                          fill;
        sepq_pkg::t_result           pending_results [$];
        int unsigned                 mismatches;
        int unsigned                 results_seen;
        int unsigned                 inserts_stored;
        int unsigned                 full_drops;
        int unsigned                 empty_pops;
        int unsigned                 events_popped;
        int                          peak_fill;

        function void note_operation(logic act, logic [sepq_pkg::TIME_W-1:0] key,
                                     logic [sepq_pkg::KIND_W-1:0] kind,
                                     logic [sepq_pkg::TAG_W-1:0] tag);
            sepq_pkg::t_result r;
            int      pos;
            int      i;
            r = '0;
            r.status = sepq_pkg::STATUS_OK;
            if (act == sepq_pkg::ACT_INSERT) begin
                if (fill >= QDEPTH) begin
                    r.status = sepq_pkg::STATUS_FULL;
                    full_drops++;
                end else begin
                    pos = 0;
                    while (pos < fill && slot_time[pos] <= key)
                        pos++;
                    for (i = fill; i > pos; i--) begin
                        slot_time[i] = slot_time[i-1];
                        slot_kind[i] = slot_kind[i-1];
                        slot_tag[i]  = slot_tag[i-1];
                    end
                    slot_time[pos] = key;
                    slot_kind[pos] = kind;
                    slot_tag[pos]  = tag;
                    fill++;
                    inserts_stored++;
                    if (fill > peak_fill)
                        peak_fill = fill;
                end
            end else if (fill == 0) begin
                r.status = sepq_pkg::STATUS_EMPTY;
                empty_pops++;
            end else begin
                r.item_valid = 1'b1;
                r.out_time   = slot_time[0];
                r.out_kind   = slot_kind[0];
                r.out_tag    = slot_tag[0];
                for (i = 1; i < fill; i++) begin
                    slot_time[i-1] = slot_time[i];
                    slot_kind[i-1] = slot_kind[i];
                    slot_tag[i-1]  = slot_tag[i];
                end
                fill--;
                events_popped++;
            end
            r.occupancy = sepq_pkg::OCC_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [sepq_pkg::TIME_W-1:0] want,
                                    logic [sepq_pkg::TIME_W-1:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected 0x%0h, got 0x%0h",
                             results_seen, field, want, seen);
            end
        endfunction

        function void check_result(logic [47:0] tdata, logic [2:0] tuser);
            sepq_pkg::t_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: item returned with nothing outstanding",
                             results_seen);
                return;
            end
            want = pending_results.pop_front();
            compare_field("item_valid", sepq_pkg::TIME_W'(want.item_valid),
                          sepq_pkg::TIME_W'(tuser[0]));
            compare_field("status",     sepq_pkg::TIME_W'(want.status),
                          sepq_pkg::TIME_W'(tuser[2:1]));
            compare_field("out_time",   want.out_time, tdata[31:0]);
            compare_field("out_kind",   sepq_pkg::TIME_W'(want.out_kind),
                          sepq_pkg::TIME_W'(tdata[33:32]));
            compare_field("out_tag",    sepq_pkg::TIME_W'(want.out_tag),
                          sepq_pkg::TIME_W'(tdata[36:34]));
            compare_field("occupancy",  sepq_pkg::TIME_W'(want.occupancy),
                          sepq_pkg::TIME_W'(tdata[41:37]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // time_key[31:0], event_kind[33:32], event_tag[36:34]
    logic [0:0]  i_s_tuser  = '0;   // action[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // out_time[31:0], out_kind[33:32], out_tag[36:34],
                                    // occupancy[41:37]
    logic [2:0]  o_m_tuser;         // item_valid[0], status[2:1]

    event_queue_scoreboard tracker;
    int unsigned           tx_idle_pct  = 0;
    int unsigned           rx_idle_pct  = 0;
    int unsigned           hold_request = 0;
    int unsigned           cycle_count  = 0;
    bit                    filling      = 1'b1;

    sorted_event_priority_queue #(
        .DEPTH    (QDEPTH),
        .KEY_BITS (sepq_pkg::TIME_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, tracker.pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : rx_drive
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_result(o_m_tdata, o_m_tuser);
    end

    task automatic send_op(input logic act, input logic [sepq_pkg::TIME_W-1:0] key,
                           input logic [sepq_pkg::KIND_W-1:0] kind,
                           input logic [sepq_pkg::TAG_W-1:0] tag);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, tag, kind, key};
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        tracker.note_operation(act, key, kind, tag);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [sepq_pkg::TIME_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return sepq_pkg::TIME_W'($urandom_range(0, 15));
            1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            2:       return 32'h0010_0000 + sepq_pkg::TIME_W'($urandom_range(0, 63));
            default: return sepq_pkg::TIME_W'($urandom);
        endcase
    endfunction

    task automatic run_random(input int unsigned count, input int unsigned hold_at,
                              input int unsigned pause_at);
        int unsigned n;
        logic        act;
        for (n = 0; n < count; n++) begin
            if (n == hold_at)
                hold_request = HOLD_CYCLES;
            if (n == pause_at)
                wait_drained();
            if (filling && tracker.fill == QDEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && tracker.fill == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            if (filling)
                act = ($urandom_range(0, 99) < 80) ? sepq_pkg::ACT_INSERT
                                                   : sepq_pkg::ACT_POP;
            else
                act = ($urandom_range(0, 99) < 80) ? sepq_pkg::ACT_POP
                                                   : sepq_pkg::ACT_INSERT;
            send_op(act, pick_key(), sepq_pkg::KIND_W'($urandom),
                    sepq_pkg::TAG_W'($urandom));
        end
    endtask

    initial begin
        tracker = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 15;
        rx_idle_pct = 67;
        send_op(sepq_pkg::ACT_POP,    32'h0000_0000, 2'd0, 3'd0);
        send_op(sepq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 2'd3, 3'd7);
        send_op(sepq_pkg::ACT_INSERT, 32'h0000_0000, 2'd0, 3'd0);
        send_op(sepq_pkg::ACT_INSERT, 32'h0000_0100, 2'd1, 3'd1);
        send_op(sepq_pkg::ACT_INSERT, 32'h0000_0100, 2'd2, 3'd2);
        send_op(sepq_pkg::ACT_INSERT, 32'h0000_0100, 2'd3, 3'd5);
        send_op(sepq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 2'd1, 3'd4);
        send_op(sepq_pkg::ACT_INSERT, 32'h8000_0000, 2'd2, 3'd6);
        repeat (8)
            send_op(sepq_pkg::ACT_POP, 32'hFFFF_FFFF, 2'd3, 3'd7);
        send_op(sepq_pkg::ACT_POP,    32'h5555_AAAA, 2'd1, 3'd2);
        wait_drained();

        run_random(PHASE_ITEMS, 40, PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 67;
        rx_idle_pct = 15;
        run_random(PHASE_ITEMS, PHASE_ITEMS, 75);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS, PHASE_ITEMS, PHASE_ITEMS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d results checked: %0d events stored, %0d inserts dropped when full,",
                 tracker.results_seen, tracker.inserts_stored, tracker.full_drops);
        $display("%0d events popped, %0d pops on empty, peak occupancy %0d, %0d mismatches",
                 tracker.events_popped, tracker.empty_pops, tracker.peak_fill,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
